// ===== hdl/lwa_pkg.sv =====
// shared types, constants and exp table for the local window attention unit
package lwa_pkg;

    localparam int MAX_SEQ      = 1024;
    localparam int MAX_HEAD_DIM = 64;
    localparam int MAX_WINDOW   = 256;
    localparam int DATA_WIDTH   = 16;

    localparam int POS_W    = $clog2(MAX_SEQ);
    localparam int FEAT_W   = $clog2(MAX_HEAD_DIM);
    localparam int SB_DEPTH = MAX_WINDOW + 1;
    localparam int SLOT_W   = $clog2(SB_DEPTH);
    localparam int KV_AW    = POS_W + FEAT_W;
    localparam int KV_DEPTH = MAX_SEQ * MAX_HEAD_DIM;

    localparam int SEQ_W      = 11;
    localparam int HD_W       = 7;
    localparam int WIN_W      = 9;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int EXP_ENTRIES = 256;
    localparam int EXP_W       = 17;
    localparam int ACC_W       = 48;
    localparam int SUM_W       = 25;
    localparam int SCORE_W     = 32;
    localparam int PROD_W      = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM_USED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIDIRECTIONAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE   = 3'd4;

    typedef logic [EXP_ENTRIES-1:0][EXP_W-1:0] exp_tab_t;

    // exp(-k/32) in unsigned Q1.16, built from a fixed-point geometric series
    function automatic exp_tab_t build_exp();
        logic [65:0] acc;
        exp_tab_t    tab;
        acc = 66'd1 << 32;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            tab[k] = EXP_W'((acc + 66'd32768) >> 16);
            acc = ((acc * 66'd4162825043) + (66'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp();

    typedef struct packed {
        logic              kv_wr;
        logic              q_wr;
        logic              row_start;
        logic              dot_en;
        logic              wgt_en;
        logic              wsum_en;
        logic              first;
        logic              last;
        logic              out_load;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  row_pos;
        logic [FEAT_W-1:0] feat;
        logic [SLOT_W-1:0] slot;
    } lwa_cmd_t;

    typedef struct packed {
        logic score_done;
        logic wgt_done;
        logic div_done;
        logic out_busy;
    } lwa_sts_t;

endpackage

// ===== hdl/lwa_div.sv =====
// restoring divider, one quotient bit per cycle
module lwa_div import lwa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic             done,
    output logic [ACC_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dvs_reg, dvs_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]   rem_shift;
    logic             ge;

    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? SUM_W'(rem_shift - {1'b0, dvs_reg}) : SUM_W'(rem_shift);
            quo_next = {quo_reg[ACC_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ACC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/lwa_dp.sv =====
// datapath: key, value, query and score stores, shared mac, scaling, weights, divider
module lwa_dp import lwa_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lwa_cmd_t                     cmd,
    output lwa_sts_t                     sts,
    input  logic [POS_W-1:0]             s_position,
    input  logic [FEAT_W-1:0]            s_feature_index,
    input  logic signed [DATA_WIDTH-1:0] s_key_value,
    input  logic signed [DATA_WIDTH-1:0] s_value_value,
    input  logic signed [DATA_WIDTH-1:0] s_query_value,
    input  logic [SCALE_W-1:0]           score_scale,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [POS_W-1:0]             m_out_position,
    output logic [FEAT_W-1:0]            m_out_feature,
    output logic signed [DATA_WIDTH-1:0] m_out_value,
    output logic                         m_row_done
);

    logic signed [DATA_WIDTH-1:0] key_mem [KV_DEPTH];
    logic signed [DATA_WIDTH-1:0] val_mem [KV_DEPTH];
    logic signed [DATA_WIDTH-1:0] q_mem [MAX_HEAD_DIM];
    logic [SCORE_W-1:0]           sb_mem [SB_DEPTH];

    logic [KV_AW-1:0] wr_addr, rd_addr;
    logic signed [DATA_WIDTH-1:0] k_rd_reg, v_rd_reg, q_rd_reg;
    logic [SCORE_W-1:0] sb_rd_reg;

    // stage flags
    logic s1_dot_reg, s1_wsum_reg, s1_wgt_reg, s1_first_reg, s1_last_reg;
    logic s2_dot_reg, s2_wsum_reg, s2_wgt_reg, s2_first_reg, s2_last_reg;
    logic s3_wgt_reg, s3_last_reg;
    logic [SLOT_W-1:0] s1_slot_reg, s2_slot_reg, s3_slot_reg;

    logic signed [17:0]       mul_a;
    logic signed [15:0]       mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [33:0]              diff, kadd;
    logic [7:0]               kidx_reg;
    logic                     kok_reg;
    logic [EXP_W-1:0]         w_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     dot_done_reg, wsum_done_reg, wgt_done_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [SCORE_W-1:0] mx_reg;

    logic [34:0]              plo_reg;
    logic signed [35:0]       phi_reg;
    logic                     sc1_reg, score_done_reg;
    logic signed [55:0]       scaled;
    logic signed [39:0]       score_wide;
    logic signed [SCORE_W-1:0] score_sat;

    logic                     sb_we;
    logic [SLOT_W-1:0]        sb_wa;
    logic [SCORE_W-1:0]       sb_wd;

    logic [ACC_W-1:0]         acc_mag, dividend;
    logic                     neg_reg;
    logic                     div_done;
    logic [ACC_W-1:0]         quotient;
    logic signed [DATA_WIDTH-1:0] q_sat;

    logic                     m_valid_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic [FEAT_W-1:0]        out_feat_reg;
    logic signed [DATA_WIDTH-1:0] out_val_reg;
    logic                     out_last_reg;

    assign wr_addr = {s_position, s_feature_index};
    assign rd_addr = {cmd.pos, cmd.feat};

    always_ff @(posedge aclk) begin
        if (cmd.kv_wr) begin
            key_mem[wr_addr] <= s_key_value;
            val_mem[wr_addr] <= s_value_value;
        end
        if (cmd.q_wr) begin
            q_mem[s_feature_index] <= s_query_value;
        end
        if (sb_we) begin
            sb_mem[sb_wa] <= sb_wd;
        end
    end

    always_ff @(posedge aclk) begin
        k_rd_reg  <= key_mem[rd_addr];
        v_rd_reg  <= val_mem[rd_addr];
        q_rd_reg  <= q_mem[cmd.feat];
        sb_rd_reg <= sb_mem[cmd.slot];
    end

    // operand select: query x key for scores, weight x value for the output sum
    assign mul_a = s1_dot_reg ? {{2{q_rd_reg[DATA_WIDTH-1]}}, q_rd_reg}
                              : $signed({1'b0, sb_rd_reg[EXP_W-1:0]});
    assign mul_b = s1_dot_reg ? k_rd_reg : v_rd_reg;

    // distance from the row maximum in steps of 1/32
    assign diff = 34'($signed({{2{mx_reg[SCORE_W-1]}}, mx_reg})
                    - $signed({{2{sb_rd_reg[SCORE_W-1]}}, sb_rd_reg}));
    assign kadd = diff + 34'd1024;

    // score = floor(dot * scale / 2^16), split across two partial products
    assign scaled     = ($signed({{20{phi_reg[35]}}, phi_reg}) <<< 19)
                        + $signed({21'b0, plo_reg});
    assign score_wide = scaled[55:16];
    always_comb begin
        if (score_wide[39:31] == {9{score_wide[31]}}) begin
            score_sat = score_wide[31:0];
        end else if (score_wide[39]) begin
            score_sat = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            score_sat = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    assign sb_we = sc1_reg | s3_wgt_reg;
    assign sb_wa = sc1_reg ? cmd.slot : s3_slot_reg;
    assign sb_wd = sc1_reg ? score_sat : {{(SCORE_W-EXP_W){1'b0}}, w_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_dot_reg     <= 1'b0;
            s1_wsum_reg    <= 1'b0;
            s1_wgt_reg     <= 1'b0;
            s2_dot_reg     <= 1'b0;
            s2_wsum_reg    <= 1'b0;
            s2_wgt_reg     <= 1'b0;
            s3_wgt_reg     <= 1'b0;
            dot_done_reg   <= 1'b0;
            wsum_done_reg  <= 1'b0;
            wgt_done_reg   <= 1'b0;
            sc1_reg        <= 1'b0;
            score_done_reg <= 1'b0;
        end else begin
            s1_dot_reg     <= cmd.dot_en;
            s1_wsum_reg    <= cmd.wsum_en;
            s1_wgt_reg     <= cmd.wgt_en;
            s2_dot_reg     <= s1_dot_reg;
            s2_wsum_reg    <= s1_wsum_reg;
            s2_wgt_reg     <= s1_wgt_reg;
            s3_wgt_reg     <= s2_wgt_reg;
            dot_done_reg   <= s2_dot_reg & s2_last_reg;
            wsum_done_reg  <= s2_wsum_reg & s2_last_reg;
            wgt_done_reg   <= s3_wgt_reg & s3_last_reg;
            sc1_reg        <= dot_done_reg;
            score_done_reg <= sc1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_slot_reg  <= cmd.slot;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_slot_reg  <= s1_slot_reg;
        s3_last_reg  <= s2_last_reg;
        s3_slot_reg  <= s2_slot_reg;
        prod_reg     <= mul_a * mul_b;
        kidx_reg     <= kadd[18:11];
        kok_reg      <= ~|kadd[33:19];
        w_reg        <= kok_reg ? EXP_TAB[kidx_reg] : '0;
        if (s2_dot_reg || s2_wsum_reg) begin
            acc_reg <= (s2_first_reg ? '0 : acc_reg)
                       + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (dot_done_reg) begin
            plo_reg <= acc_reg[18:0] * score_scale;
            phi_reg <= $signed(acc_reg[37:19]) * $signed({1'b0, score_scale});
        end
        if (cmd.row_start) begin
            mx_reg  <= {1'b1, {(SCORE_W-1){1'b0}}};
            sum_reg <= '0;
        end else begin
            if (sc1_reg && (score_sat > mx_reg)) begin
                mx_reg <= score_sat;
            end
            if (s3_wgt_reg) begin
                sum_reg <= sum_reg + {{(SUM_W-EXP_W){1'b0}}, w_reg};
            end
        end
        if (wsum_done_reg) begin
            neg_reg <= acc_reg[ACC_W-1];
        end
    end

    // round half away from zero: (|acc| + sum/2) / sum
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign dividend = acc_mag + {{(ACC_W-SUM_W){1'b0}}, sum_reg >> 1};

    lwa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (wsum_done_reg),
        .dividend (dividend),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        if (neg_reg) begin
            if (quotient > ACC_W'(32768)) begin
                q_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end else begin
                q_sat = DATA_WIDTH'(-quotient[DATA_WIDTH-1:0]);
            end
        end else begin
            if (quotient > ACC_W'(32767)) begin
                q_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end else begin
                q_sat = quotient[DATA_WIDTH-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_pos_reg  <= cmd.row_pos;
            out_feat_reg <= cmd.feat;
            out_val_reg  <= q_sat;
            out_last_reg <= cmd.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_position = out_pos_reg;
    assign m_out_feature  = out_feat_reg;
    assign m_out_value    = out_val_reg;
    assign m_row_done     = out_last_reg;

    assign sts.score_done = score_done_reg;
    assign sts.wgt_done   = wgt_done_reg;
    assign sts.div_done   = div_done;
    assign sts.out_busy   = m_valid_reg & ~m_ready;

endmodule

// ===== hdl/lwa_ctrl.sv =====
// controller: input handshake, window bounds and the score, weight and output loops
module lwa_ctrl import lwa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [POS_W-1:0]  s_position,
    input  logic [FEAT_W-1:0] s_feature_index,
    input  logic [SEQ_W-1:0]  seq_eff,
    input  logic [HD_W-1:0]   hd_eff,
    input  logic [WIN_W-1:0]  win_eff,
    input  logic              bidir,
    input  lwa_sts_t          sts,
    output lwa_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DOT  = 3'd1;
    localparam logic [2:0] ST_DOTW = 3'd2;
    localparam logic [2:0] ST_WGT  = 3'd3;
    localparam logic [2:0] ST_WGTW = 3'd4;
    localparam logic [2:0] ST_VAL  = 3'd5;
    localparam logic [2:0] ST_DIVW = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  j_reg, j_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  jlast_reg, jlast_next;
    logic [POS_W-1:0]  rowpos_reg, rowpos_next;
    logic [FEAT_W-1:0] d_reg, d_next;
    logic [FEAT_W-1:0] hdl_reg, hdl_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] nlast_reg, nlast_next;

    logic              accept, trigger;
    logic [FEAT_W-1:0] hd_last;
    logic [WIN_W-1:0]  half, lo_off;
    logic signed [POS_W+1:0] st_raw;
    logic [POS_W-1:0]  win_start, win_jlast;
    logic [SEQ_W-1:0]  hi_raw, seq_m1;

    assign accept  = s_valid && (state_reg == ST_IDLE);
    assign s_ready = (state_reg == ST_IDLE);
    assign hd_last = FEAT_W'(hd_eff - 1'b1);
    assign trigger = s_command && (s_feature_index == hd_last)
                     && ({1'b0, s_position} < seq_eff);

    // window bounds, clipped to the sequence
    assign half      = win_eff >> 1;
    assign lo_off    = bidir ? half : WIN_W'(win_eff - 1'b1);
    assign st_raw    = $signed({2'b0, s_position}) - $signed({3'b0, lo_off});
    assign win_start = st_raw[POS_W+1] ? '0 : st_raw[POS_W-1:0];
    assign hi_raw    = bidir ? ({1'b0, s_position} + SEQ_W'(half)) : {1'b0, s_position};
    assign seq_m1    = seq_eff - 1'b1;
    assign win_jlast = (hi_raw > seq_m1) ? seq_m1[POS_W-1:0] : hi_raw[POS_W-1:0];

    always_comb begin
        state_next  = state_reg;
        j_next      = j_reg;
        start_next  = start_reg;
        jlast_next  = jlast_reg;
        rowpos_next = rowpos_reg;
        d_next      = d_reg;
        hdl_next    = hdl_reg;
        slot_next   = slot_reg;
        nlast_next  = nlast_reg;
        cmd         = '0;
        cmd.pos     = j_reg;
        cmd.row_pos = rowpos_reg;
        cmd.feat    = d_reg;
        cmd.slot    = slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.kv_wr = !s_command;
                    cmd.q_wr  = s_command;
                    if (trigger) begin
                        cmd.row_start = 1'b1;
                        rowpos_next   = s_position;
                        start_next    = win_start;
                        j_next        = win_start;
                        jlast_next    = win_jlast;
                        nlast_next    = SLOT_W'(win_jlast - win_start);
                        hdl_next      = hd_last;
                        d_next        = '0;
                        slot_next     = '0;
                        state_next    = ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                cmd.dot_en = 1'b1;
                cmd.first  = (d_reg == '0);
                cmd.last   = (d_reg == hdl_reg);
                if (d_reg == hdl_reg) begin
                    d_next     = '0;
                    state_next = ST_DOTW;
                end else begin
                    d_next = d_reg + 1'b1;
                end
            end
            ST_DOTW: begin
                if (sts.score_done) begin
                    if (j_reg == jlast_reg) begin
                        slot_next  = '0;
                        state_next = ST_WGT;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_DOT;
                    end
                end
            end
            ST_WGT: begin
                cmd.wgt_en = 1'b1;
                cmd.last   = (slot_reg == nlast_reg);
                if (slot_reg == nlast_reg) begin
                    state_next = ST_WGTW;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_WGTW: begin
                if (sts.wgt_done) begin
                    j_next     = start_reg;
                    slot_next  = '0;
                    d_next     = '0;
                    state_next = ST_VAL;
                end
            end
            ST_VAL: begin
                cmd.wsum_en = 1'b1;
                cmd.first   = (slot_reg == '0);
                cmd.last    = (slot_reg == nlast_reg);
                if (slot_reg == nlast_reg) begin
                    state_next = ST_DIVW;
                end else begin
                    j_next    = j_reg + 1'b1;
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_DIVW: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.last = (d_reg == hdl_reg);
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    if (d_reg == hdl_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        j_next     = start_reg;
                        slot_next  = '0;
                        state_next = ST_VAL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        j_reg      <= j_next;
        start_reg  <= start_next;
        jlast_reg  <= jlast_next;
        rowpos_reg <= rowpos_next;
        d_reg      <= d_next;
        hdl_reg    <= hdl_next;
        slot_reg   <= slot_next;
        nlast_reg  <= nlast_next;
    end

endmodule

// ===== hdl/local_window_attention_unit.sv =====
// top level of the local window attention unit: configuration registers, controller, datapath
//
// channel   dir  handshake             payload
// s_*       in   s_valid / s_ready     command, position, feature_index, key/value/query
// m_*       out  m_valid / m_ready     out_position, out_feature, out_value, row_done
// cfg_*     in   cfg_we (no wait)      cfg_addr selects register, cfg_wdata
//
// a load or a query element that does not end a row only writes the key, value or query store
// a row ending query with W window slots and D features runs the score, weight and output loops,
// which output stalls can hold: one shared mac path and a 48-step divider
// s_ready is high only while no row is in progress; results wait in one output register
// reset is synchronous and clears control state only; stores need no clearing pass
module local_window_attention_unit import lwa_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [POS_W-1:0]             s_position,
    input  logic [FEAT_W-1:0]            s_feature_index,
    input  logic signed [DATA_WIDTH-1:0] s_key_value,
    input  logic signed [DATA_WIDTH-1:0] s_value_value,
    input  logic signed [DATA_WIDTH-1:0] s_query_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [POS_W-1:0]             m_out_position,
    output logic [FEAT_W-1:0]            m_out_feature,
    output logic signed [DATA_WIDTH-1:0] m_out_value,
    output logic                         m_row_done,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

    logic [SEQ_W-1:0]   seq_reg;
    logic [HD_W-1:0]    hd_reg;
    logic [WIN_W-1:0]   win_reg;
    logic               bidir_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic [SEQ_W-1:0]   seq_eff;
    logic [HD_W-1:0]    hd_eff;
    logic [WIN_W-1:0]   win_eff;

    lwa_cmd_t cmd;
    lwa_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SEQ_W'(1024);
            hd_reg    <= HD_W'(64);
            win_reg   <= WIN_W'(64);
            bidir_reg <= 1'b1;
            scale_reg <= SCALE_W'(8192);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SEQ_LENGTH:    seq_reg   <= cfg_wdata[SEQ_W-1:0];
                CFG_HEAD_DIM_USED: hd_reg    <= cfg_wdata[HD_W-1:0];
                CFG_WINDOW_SIZE:   win_reg   <= cfg_wdata[WIN_W-1:0];
                CFG_BIDIRECTIONAL: bidir_reg <= cfg_wdata[0];
                CFG_SCORE_SCALE:   scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero counts as one, larger values clip to the store sizes
    assign seq_eff = (seq_reg == '0) ? SEQ_W'(1)
                   : (seq_reg > SEQ_W'(MAX_SEQ)) ? SEQ_W'(MAX_SEQ) : seq_reg;
    assign hd_eff  = (hd_reg == '0) ? HD_W'(1)
                   : (hd_reg > HD_W'(MAX_HEAD_DIM)) ? HD_W'(MAX_HEAD_DIM) : hd_reg;
    assign win_eff = (win_reg == '0) ? WIN_W'(1)
                   : (win_reg > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_reg;

    lwa_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_position      (s_position),
        .s_feature_index (s_feature_index),
        .seq_eff         (seq_eff),
        .hd_eff          (hd_eff),
        .win_eff         (win_eff),
        .bidir           (bidir_reg),
        .sts             (sts),
        .cmd             (cmd)
    );

    lwa_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_position      (s_position),
        .s_feature_index (s_feature_index),
        .s_key_value     (s_key_value),
        .s_value_value   (s_value_value),
        .s_query_value   (s_query_value),
        .score_scale     (scale_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_position  (m_out_position),
        .m_out_feature   (m_out_feature),
        .m_out_value     (m_out_value),
        .m_row_done      (m_row_done)
    );

endmodule

// ===== hdl/lwa_checker.sv =====
// port level checks for the local window attention unit, bound to the top level
module lwa_checker import lwa_pkg::*; (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [FEAT_W-1:0]            m_out_feature,
    input logic signed [DATA_WIDTH-1:0] m_out_value,
    input logic                         m_row_done
);

    logic [FEAT_W-1:0] exp_feat_reg;

    // features of a row come out in order from zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_feat_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_feat_reg <= m_row_done ? '0 : m_out_feature + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_out_feature))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or busy state after reset");

    a_feat_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_feature == exp_feat_reg)
        else $error("result feature out of order");

    a_no_input_while_row_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_row_done |-> !s_ready)
        else $error("input taken in the middle of a row");

endmodule

bind local_window_attention_unit lwa_checker u_lwa_checker (.*);
